FILE: design/ctds_pkg.sv
// Shared types, status codes and saturating helpers for the cyclic tridiagonal solver.
`default_nettype none

package ctds_pkg;

  typedef struct packed {
    logic signed [31:0] coef_lower;
    logic signed [31:0] coef_diag;
    logic signed [31:0] coef_upper;
    logic signed [31:0] rhs_value;
    logic               last_row;
  } row_t;

  typedef struct packed {
    logic signed [31:0] solution;
    logic [5:0]         row_index;
    logic               final_value;
    logic [1:0]         status;
  } sol_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR = 2'd1;
  localparam logic [1:0] STATUS_SHORT    = 2'd2;

  localparam logic signed [31:0] FX_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] sat33(input logic [32:0] v);
    logic signed [31:0] r;
    if (v[32] == v[31]) r = v[31:0];
    else if (v[32]) r = FX_MIN;
    else r = FX_MAX;
    return r;
  endfunction

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) r = FX_MAX;
    else if (v < -64'sh0000_0000_8000_0000) r = FX_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return sat33({a[31], a} + {b[31], b});
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return sat33({a[31], a} - {b[31], b});
  endfunction

endpackage

`default_nettype wire

FILE: design/cyclic_tridiagonal_solver.sv
// Top level of the cyclic tridiagonal solver: row stores, sequencer, multiplier and divider.
//
//   port group   dir  handshake              word
//   row          in   row_valid / row_stall  row_word (row_t)
//   sol          out  sol_valid / sol_stall  sol_word (sol_t)
//
// Loading accepts one row word per cycle while row_stall is low. The solve runs one
// multiplier and one restoring divider under a sequencer: up to three products and
// three quotients per row on the forward sweep, two products per row backward, and
// one product per emitted word, which is held while sol_stall is high. row_stall stays
// high from the last row until the final solution word is taken. rst is synchronous
// and clears the sequencer, the row count and the singular flag; the stores are not cleared.
`default_nettype none

module cyclic_tridiagonal_solver
  import ctds_pkg::*;
#(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  row_valid,
  output logic row_stall,
  input  row_t row_word,
  output logic sol_valid,
  input  wire  sol_stall,
  output sol_t sol_word
);

  localparam int IDX_W = $clog2(MAX_ROWS);
  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int NW    = 32 + FRAC_BITS;
  localparam int DC_W  = $clog2(NW + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_F_RD  = 5'd1;
  localparam logic [4:0] S_F_LAT = 5'd2;
  localparam logic [4:0] S_F_P1  = 5'd3;
  localparam logic [4:0] S_F_P2  = 5'd4;
  localparam logic [4:0] S_F_P3  = 5'd5;
  localparam logic [4:0] S_F_D1  = 5'd6;
  localparam logic [4:0] S_F_D2  = 5'd7;
  localparam logic [4:0] S_F_D3  = 5'd8;
  localparam logic [4:0] S_F_WR  = 5'd9;
  localparam logic [4:0] S_B_RD  = 5'd10;
  localparam logic [4:0] S_B_LAT = 5'd11;
  localparam logic [4:0] S_B_M2  = 5'd12;
  localparam logic [4:0] S_B_M3  = 5'd13;
  localparam logic [4:0] S_B_WR  = 5'd14;
  localparam logic [4:0] S_L_RD  = 5'd15;
  localparam logic [4:0] S_L_LAT = 5'd16;
  localparam logic [4:0] S_L_M2  = 5'd17;
  localparam logic [4:0] S_L_M3  = 5'd18;
  localparam logic [4:0] S_L_M4  = 5'd19;
  localparam logic [4:0] S_L_M5  = 5'd20;
  localparam logic [4:0] S_L_D   = 5'd21;
  localparam logic [4:0] S_O_RD  = 5'd22;
  localparam logic [4:0] S_O_M   = 5'd23;
  localparam logic [4:0] S_O_A   = 5'd24;
  localparam logic [4:0] S_O_W   = 5'd25;

  logic [4:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] m_rows;
  logic [IDX_W-1:0] idx;
  logic             singular;
  logic             short_sys;

  logic signed [31:0] mem_lower [MAX_ROWS];
  logic signed [31:0] mem_diag  [MAX_ROWS];
  logic signed [31:0] mem_upper [MAX_ROWS];
  logic signed [31:0] mem_rhs   [MAX_ROWS];
  logic signed [31:0] mem_ratio [MAX_ROWS];
  logic signed [31:0] mem_corner[MAX_ROWS];

  logic signed [31:0] rd_l, rd_d, rd_u, rd_b, rd_r, rd_c;
  logic signed [31:0] wl, wd, wu, wb, wr, wc;
  logic signed [31:0] piv, rn, yn, cn, rp, yp, cp, ylast, clast, xl;
  logic signed [63:0] prod;
  logic signed [31:0] mres;

  logic             load_acc;
  logic [IDX_W-1:0] wr_idx;
  logic             we_rhs, we_fwd;
  logic signed [31:0] rhs_wdata;

  // Divider signals.
  logic               dv_start, dv_issued, dv_busy, dv_done, dv_neg;
  logic signed [31:0] dv_n, dv_d, dv_q;
  logic [DC_W-1:0]    dv_cnt;
  logic [31:0]        dv_rem, dv_den;
  logic [NW-1:0]      dv_num, dv_quo;
  logic [32:0]        dv_trial;
  logic [31:0]        n_mag, d_mag;
  logic signed [NW:0] dv_signed;

  logic is_m2, is_last, in_div;

  assign row_stall = (state != S_IDLE);
  assign load_acc  = row_valid && !row_stall;
  assign mres      = sat64(prod >>> FRAC_BITS);
  assign is_m2     = (CNT_W'(idx) == m_rows - CNT_W'(2));
  assign is_last   = (CNT_W'(idx) == m_rows - CNT_W'(1));

  assign wr_idx    = (state == S_IDLE) ? count[IDX_W-1:0] : idx;
  assign we_fwd    = (state == S_F_WR);
  assign we_rhs    = (load_acc && count < CNT_W'(MAX_ROWS)) || we_fwd || (state == S_B_WR);
  always_comb begin
    unique case (state)
      S_IDLE:  rhs_wdata = row_word.rhs_value;
      S_F_WR:  rhs_wdata = yn;
      default: rhs_wdata = yp;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_acc && count < CNT_W'(MAX_ROWS)) begin
      mem_lower[wr_idx] <= row_word.coef_lower;
      mem_diag[wr_idx]  <= row_word.coef_diag;
      mem_upper[wr_idx] <= row_word.coef_upper;
    end
    if (we_rhs) mem_rhs[wr_idx] <= rhs_wdata;
    if (we_fwd) mem_ratio[wr_idx] <= rn;
    if (we_fwd) mem_corner[wr_idx] <= cn;
    else if (state == S_B_WR) mem_corner[wr_idx] <= cp;
    rd_l <= mem_lower[idx];
    rd_d <= mem_diag[idx];
    rd_u <= mem_upper[idx];
    rd_b <= mem_rhs[idx];
    rd_r <= mem_ratio[idx];
    rd_c <= mem_corner[idx];
  end

  // Divider operand selection and start.
  assign in_div = (state == S_F_D1) || (state == S_F_D2) || (state == S_F_D3) ||
                  (state == S_L_D);
  assign dv_start = in_div && !dv_issued;
  always_comb begin
    dv_n = yn;
    if (state == S_F_D1) dv_n = wu;
    else if (state == S_F_D3) dv_n = cn;
    dv_d = piv;
  end
  assign n_mag     = dv_n[31] ? 32'(-dv_n) : dv_n;
  assign d_mag     = dv_d[31] ? 32'(-dv_d) : dv_d;
  assign dv_trial  = {dv_rem, dv_num[NW-1]};
  assign dv_signed = dv_neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_done <= 1'b0;
    end else begin
      dv_done <= 1'b0;
      if (dv_start) begin
        if (dv_d == 32'sd0) begin
          dv_done <= 1'b1;
          if (dv_n > 32'sd0) dv_q <= FX_MAX;
          else if (dv_n < 32'sd0) dv_q <= FX_MIN;
          else dv_q <= 32'sd0;
        end else begin
          dv_busy <= 1'b1;
          dv_cnt  <= DC_W'(NW);
          dv_rem  <= '0;
          dv_num  <= {n_mag, {FRAC_BITS{1'b0}}};
          dv_den  <= d_mag;
          dv_neg  <= dv_n[31] ^ dv_d[31];
        end
      end else if (dv_busy) begin
        if (dv_cnt == '0) begin
          dv_busy <= 1'b0;
          dv_done <= 1'b1;
          dv_q    <= sat64(64'(dv_signed));
        end else begin
          dv_cnt <= dv_cnt - DC_W'(1);
          dv_num <= dv_num << 1;
          if (dv_trial >= {1'b0, dv_den}) begin
            dv_rem <= 32'(dv_trial - {1'b0, dv_den});
            dv_quo <= {dv_quo[NW-2:0], 1'b1};
          end else begin
            dv_rem <= dv_trial[31:0];
            dv_quo <= {dv_quo[NW-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      singular  <= 1'b0;
      sol_valid <= 1'b0;
      dv_issued <= 1'b0;
      short_sys <= 1'b0;
    end else begin
      if (dv_start && dv_d == 32'sd0) singular <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (load_acc) begin
            if (row_word.last_row) begin
              m_rows <= (count < CNT_W'(MAX_ROWS)) ? count + CNT_W'(1) : count;
              short_sys <= (count < CNT_W'(2));
              idx <= '0;
              state <= (count < CNT_W'(2)) ? S_O_RD : S_F_RD;
            end else if (count < CNT_W'(MAX_ROWS)) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        S_F_RD: state <= S_F_LAT;
        S_F_LAT: begin
          wl <= rd_l; wd <= rd_d; wu <= rd_u; wb <= rd_b;
          if (idx == '0) begin
            piv <= rd_d;
            yn  <= rd_b;
            cn  <= fx_sub(32'sd0, rd_l);
            state <= S_F_D1;
          end else begin
            prod  <= rd_l * rp;
            state <= S_F_P1;
          end
        end
        S_F_P1: begin
          piv <= fx_sub(wd, mres);
          prod <= wl * yp;
          state <= S_F_P2;
        end
        S_F_P2: begin
          yn <= fx_sub(wb, mres);
          prod <= wl * cp;
          state <= S_F_P3;
        end
        S_F_P3: begin
          // On rows after row 0, the corner column starts as minus the upper coefficient on row M-2 only.
          cn <= fx_sub(is_m2 ? fx_sub(32'sd0, wu) : 32'sd0, mres);
          state <= S_F_D1;
        end
        S_F_D1, S_F_D2, S_F_D3, S_L_D: begin
          if (!dv_issued) begin
            dv_issued <= 1'b1;
          end else if (dv_done) begin
            dv_issued <= 1'b0;
            unique case (state)
              S_F_D1: begin rn <= dv_q; state <= S_F_D2; end
              S_F_D2: begin yn <= dv_q; state <= S_F_D3; end
              S_F_D3: begin cn <= dv_q; state <= S_F_WR; end
              default: begin xl <= dv_q; idx <= '0; state <= S_O_RD; end
            endcase
          end
        end
        S_F_WR: begin
          rp <= rn; yp <= yn; cp <= cn;
          if (is_m2) begin
            ylast <= yn; clast <= cn;
            idx <= IDX_W'(m_rows - CNT_W'(3));
            state <= S_B_RD;
          end else begin
            idx <= idx + IDX_W'(1);
            state <= S_F_RD;
          end
        end
        S_B_RD: state <= S_B_LAT;
        S_B_LAT: begin
          wb <= rd_b; wr <= rd_r; wc <= rd_c;
          prod <= rd_r * yp;
          state <= S_B_M2;
        end
        S_B_M2: begin
          yp <= fx_sub(wb, mres);
          prod <= wr * cp;
          state <= S_B_M3;
        end
        S_B_M3: begin
          cp <= fx_sub(wc, mres);
          state <= S_B_WR;
        end
        S_B_WR: begin
          if (idx == '0) begin
            idx <= IDX_W'(m_rows - CNT_W'(1));
            state <= S_L_RD;
          end else begin
            idx <= idx - IDX_W'(1);
            state <= S_B_RD;
          end
        end
        S_L_RD: state <= S_L_LAT;
        S_L_LAT: begin
          wl <= rd_l; wd <= rd_d; wu <= rd_u; wb <= rd_b;
          prod <= rd_l * clast;
          state <= S_L_M2;
        end
        S_L_M2: begin
          piv <= fx_add(wd, mres);
          prod <= wu * cp;
          state <= S_L_M3;
        end
        S_L_M3: begin
          piv <= fx_add(piv, mres);
          prod <= wl * ylast;
          state <= S_L_M4;
        end
        S_L_M4: begin
          yn <= fx_sub(wb, mres);
          prod <= wu * yp;
          state <= S_L_M5;
        end
        S_L_M5: begin
          yn <= fx_sub(yn, mres);
          state <= S_L_D;
        end
        S_O_RD: state <= S_O_M;
        S_O_M: begin
          wb <= rd_b;
          prod <= rd_c * xl;
          state <= S_O_A;
        end
        S_O_A: begin
          sol_valid <= 1'b1;
          sol_word.row_index   <= 6'(idx);
          sol_word.final_value <= is_last;
          if (short_sys) begin
            sol_word.solution <= 32'sd0;
            sol_word.status   <= STATUS_SHORT;
          end else begin
            sol_word.solution <= is_last ? xl : fx_add(wb, mres);
            sol_word.status   <= singular ? STATUS_SINGULAR : STATUS_OK;
          end
          state <= S_O_W;
        end
        S_O_W: begin
          if (!sol_stall) begin
            sol_valid <= 1'b0;
            if (is_last) begin
              count <= '0;
              singular <= 1'b0;
              state <= S_IDLE;
            end else begin
              idx <= idx + IDX_W'(1);
              state <= S_O_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    sol_valid |-> row_stall) else $error("row accepted while a solution word is pending");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (sol_valid && sol_word.status == STATUS_SHORT) |-> (sol_word.solution == 32'sd0))
    else $error("short system word carries a nonzero solution");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    dv_start |-> !dv_busy) else $error("divider started while busy");

endmodule

`default_nettype wire

FILE: test/ctds_checker.sv
// Checker for the cyclic tridiagonal solver: predicts solution words from accepted rows.
`default_nettype none

module ctds_checker
  import ctds_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  row_valid,
  input  wire  row_stall,
  input  row_t row_word,
  input  wire  sol_valid,
  input  wire  sol_stall,
  input  sol_t sol_word,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int FRAC = 16;
  localparam longint QMAX = 64'sh0000_0000_7fff_ffff;
  localparam longint QMIN = -64'sh0000_0000_8000_0000;

  int lo [DEPTH];
  int dg [DEPTH];
  int up [DEPTH];
  int rh [DEPTH];
  int rt [DEPTH];
  int cn [DEPTH];
  int loaded;
  bit zero_pivot;
  sol_t expected_words[$];

  function automatic int clampq(longint v);
    if (v > QMAX) return int'(QMAX);
    if (v < QMIN) return int'(QMIN);
    return int'(v);
  endfunction

  function automatic int addq(int a, int b);
    return clampq(longint'(a) + longint'(b));
  endfunction

  function automatic int subq(int a, int b);
    return clampq(longint'(a) - longint'(b));
  endfunction

  // Arithmetic shift floors, which is the rounding the block uses for products.
  function automatic int mulq(int a, int b);
    return clampq((longint'(a) * longint'(b)) >>> FRAC);
  endfunction

  function automatic int divq(int n, int d);
    longint num;
    num = longint'(n) <<< FRAC;
    if (d == 0) begin
      zero_pivot = 1'b1;
      if (num > 0) return int'(QMAX);
      if (num < 0) return int'(QMIN);
      return 0;
    end
    return clampq(num / longint'(d));
  endfunction

  // Two Thomas sweeps (right-hand side and corner column), then recombination.
  task automatic solve_rows(int m);
    int piv;
    int num;
    int a;
    for (int i = 0; i < m; i++) cn[i] = 0;
    cn[0] = subq(0, lo[0]);
    cn[m-2] = subq(0, up[m-2]);
    rt[0] = divq(up[0], dg[0]);
    rh[0] = divq(rh[0], dg[0]);
    cn[0] = divq(cn[0], dg[0]);
    for (int i = 1; i <= m - 2; i++) begin
      a = lo[i];
      piv = subq(dg[i], mulq(a, rt[i-1]));
      rt[i] = divq(up[i], piv);
      rh[i] = divq(subq(rh[i], mulq(a, rh[i-1])), piv);
      cn[i] = divq(subq(cn[i], mulq(a, cn[i-1])), piv);
    end
    for (int i = m - 3; i >= 0; i--) begin
      rh[i] = subq(rh[i], mulq(rt[i], rh[i+1]));
      cn[i] = subq(cn[i], mulq(rt[i], cn[i+1]));
    end
    piv = addq(addq(dg[m-1], mulq(lo[m-1], cn[m-2])), mulq(up[m-1], cn[0]));
    num = subq(subq(rh[m-1], mulq(lo[m-1], rh[m-2])), mulq(up[m-1], rh[0]));
    rh[m-1] = divq(num, piv);
    for (int i = 0; i + 1 < m; i++) rh[i] = addq(rh[i], mulq(cn[i], rh[m-1]));
  endtask

  task automatic take_row(row_t r);
    sol_t s;
    logic [1:0] st;
    if (loaded < DEPTH) begin
      lo[loaded] = r.coef_lower;
      dg[loaded] = r.coef_diag;
      up[loaded] = r.coef_upper;
      rh[loaded] = r.rhs_value;
      loaded++;
    end
    if (!r.last_row) return;
    if (loaded < 3) begin
      st = STATUS_SHORT;
    end else begin
      solve_rows(loaded);
      st = zero_pivot ? STATUS_SINGULAR : STATUS_OK;
    end
    for (int k = 0; k < loaded; k++) begin
      s.solution = (st == STATUS_SHORT) ? 32'sd0 : rh[k];
      s.row_index = k[5:0];
      s.final_value = (k + 1 == loaded);
      s.status = st;
      expected_words.push_back(s);
    end
    loaded = 0;
    zero_pivot = 1'b0;
  endtask

  task automatic check_word(sol_t got);
    sol_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected solution word %h", $time, got);
      errors++;
      return;
    end
    want = expected_words.pop_front();
    if (got.solution !== want.solution) begin
      $display("%0t: row %0d solution expected %h got %h", $time, want.row_index,
               want.solution, got.solution);
      errors++;
    end
    if (got.row_index !== want.row_index) begin
      $display("%0t: row_index expected %0d got %0d", $time, want.row_index, got.row_index);
      errors++;
    end
    if (got.final_value !== want.final_value) begin
      $display("%0t: row %0d final_value expected %b got %b", $time, want.row_index,
               want.final_value, got.final_value);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: row %0d status expected %0d got %0d", $time, want.row_index,
               want.status, got.status);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    loaded = 0;
    zero_pivot = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      loaded = 0;
      zero_pivot = 1'b0;
    end else begin
      if (row_valid && !row_stall) take_row(row_word);
      if (sol_valid && !sol_stall) check_word(sol_word);
    end
    pending = expected_words.size();
  end

endmodule

`default_nettype wire

FILE: test/tb_cyclic_tridiagonal_solver.sv
// Testbench top for the cyclic tridiagonal solver: clock, reset, row stimulus and verdict.
`default_nettype none

module tb_cyclic_tridiagonal_solver;
  import ctds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 800000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SYS_DOMINANT = 0;
  localparam int SYS_NOISE = 1;
  localparam int SYS_ZERO_PIVOT = 2;
  localparam int SYS_MAX = 3;
  localparam int SYS_MIN = 4;

  logic clk = 1'b0;
  logic rst;
  logic row_valid;
  logic row_stall;
  row_t row_word;
  logic sol_valid;
  logic sol_stall;
  sol_t sol_word;
  int errors;
  int pending;
  int cycles = 0;
  int rows_sent = 0;
  int words_taken = 0;
  bit quick_send;
  bit quick_take;

  always #10 clk = ~clk;

  cyclic_tridiagonal_solver i_dut (
    .clk(clk), .rst(rst),
    .row_valid(row_valid), .row_stall(row_stall), .row_word(row_word),
    .sol_valid(sol_valid), .sol_stall(sol_stall), .sol_word(sol_word)
  );

  ctds_checker i_checker (
    .clk(clk), .rst(rst),
    .row_valid(row_valid), .row_stall(row_stall), .row_word(row_word),
    .sol_valid(sol_valid), .sol_stall(sol_stall), .sol_word(sol_word),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int signed_range(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_row(row_t r);
    int gap;
    gap = quick_send ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      row_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_valid <= 1'b1;
    row_word <= r;
    @(posedge clk);
    while (row_stall) @(posedge clk);
    rows_sent++;
  endtask

  task automatic send_system(int m, int kind);
    row_t r;
    quick_send = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < m; i++) begin
      case (kind)
        SYS_NOISE: begin
          r.coef_lower = $urandom;
          r.coef_diag = $urandom;
          r.coef_upper = $urandom;
          r.rhs_value = $urandom;
        end
        SYS_MAX: begin
          r.coef_lower = FX_MAX;
          r.coef_diag = FX_MAX;
          r.coef_upper = FX_MAX;
          r.rhs_value = FX_MAX;
        end
        SYS_MIN: begin
          r.coef_lower = FX_MIN;
          r.coef_diag = FX_MIN;
          r.coef_upper = FX_MIN;
          r.rhs_value = FX_MIN;
        end
        default: begin
          // Diagonally dominant rows keep the pivots well away from zero.
          r.coef_lower = signed_range(65536);
          r.coef_upper = signed_range(65536);
          r.coef_diag = int'($urandom_range(3 << 16, 6 << 16));
          if ($urandom_range(0, 1)) r.coef_diag = -r.coef_diag;
          r.rhs_value = signed_range(100 << 16);
        end
      endcase
      if (kind == SYS_ZERO_PIVOT) begin
        r.coef_diag = 32'sd0;
        // Row 0 divides zero by zero; row 1 then divides by a zero pivot too.
        if (i == 0) begin
          r.coef_upper = 32'sd0;
          r.rhs_value = 32'sd0;
          r.coef_lower = 32'sd0;
        end
      end
      r.last_row = (i == m - 1);
      send_row(r);
    end
  endtask

  // Receiver: random stalls per word, quiet stretches, and one long hold-off.
  initial begin
    int w;
    sol_stall <= 1'b0;
    quick_take = 1'b0;
    forever begin
      if (words_taken == 20) w = HOLD_CYCLES;
      else w = quick_take ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        sol_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      sol_stall <= 1'b0;
      @(posedge clk);
      while (!sol_valid) @(posedge clk);
      words_taken++;
      if (words_taken % 32 == 0) quick_take = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    int m;
    int kind;
    int rand_rows;
    bit big_done;
    bit over_done;
    rst <= 1'b1;
    row_valid <= 1'b0;
    row_word <= '0;
    quick_send = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_system(1, SYS_DOMINANT);
    send_system(2, SYS_DOMINANT);
    send_system(3, SYS_MAX);
    send_system(3, SYS_MIN);
    send_system(3, SYS_ZERO_PIVOT);
    send_system(4, SYS_NOISE);

    rand_rows = 0;
    big_done = 1'b0;
    over_done = 1'b0;
    while (rand_rows < 150 || !big_done || !over_done) begin
      if (!big_done && rand_rows > 40) begin
        m = 64;
        big_done = 1'b1;
      end else if (!over_done && rand_rows > 100) begin
        m = 66;
        over_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        m = $urandom_range(1, 2);
      end else begin
        m = $urandom_range(3, 9);
      end
      w_kind: begin
        kind = $urandom_range(0, 9);
        if (kind < 8) kind = SYS_DOMINANT;
        else if (kind == 8) kind = SYS_NOISE;
        else kind = SYS_ZERO_PIVOT;
      end
      send_system(m, kind);
      rand_rows += m;
    end

    row_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
